[hw/rtl/sept_pkg.sv]
package sept_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 16;

    localparam logic [CNT_W-1:0] NONE_MARK = CNT_W'(MAX_POINTS);

    // operation codes
    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_DELETE  = 3'd1;
    localparam logic [2:0] KIND_MOVE    = 3'd2;
    localparam logic [2:0] KIND_SETMARK = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // marker slots
    localparam int MARK_SUS_BEGIN  = 0;
    localparam int MARK_SUS_END    = 1;
    localparam int MARK_LOOP_START = 2;
    localparam int MARK_LOOP_END   = 3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [CNT_W-1:0]  point_index;
        logic [DATA_W-1:0] point_time;
        logic [DATA_W-1:0] point_value;
        logic [1:0]        marker_select;
    } op_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CNT_W-1:0]  result_index;
        logic [DATA_W-1:0] read_time;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  count_now;
        logic [CNT_W-1:0]  sustain_first;
        logic [CNT_W-1:0]  sustain_last;
        logic [CNT_W-1:0]  loop_first;
        logic [CNT_W-1:0]  loop_last;
    } result_t;

    typedef logic [3:0][CNT_W-1:0] mark_vec_t;

    typedef enum logic [1:0] {
        WM_INSERT = 2'd0,
        WM_DELETE = 2'd1,
        WM_MOVE   = 2'd2,
        WM_READ   = 2'd3
    } walk_mode_t;

    typedef struct packed {
        logic              go;
        walk_mode_t        mode;
        logic [IDX_W-1:0]  start_pos;
        logic [IDX_W-1:0]  last_pos;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] v;
    } walk_req_t;

    typedef struct packed {
        logic              done;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] v;
    } walk_rsp_t;

    typedef enum logic [1:0] {
        MK_INS  = 2'd0,
        MK_DEL  = 2'd1,
        MK_MOVE = 2'd2,
        MK_SET  = 2'd3
    } mark_op_t;

    typedef struct packed {
        logic             en;
        mark_op_t         op;
        logic [CNT_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [1:0]       sel;
    } mark_upd_t;

endpackage

[hw/rtl/sorted_envelope_point_table_core.sv]
// Sorted envelope point table: up to 64 (time, value) points kept in
// ascending time order, plus sustain and loop marker pairs.
//
// Command channel: an operation transfers at a rising edge with start
// high and busy low. Result channel: done is high for exactly one cycle
// and result is valid in that cycle; the receiver must take it then.
//
// Errors, marker writes and unused kinds give done in the cycle after
// the transfer. Insert, delete and move walk the point memory through
// one compare unit, one slot per step, and read fetches a single slot:
//   read  : the slot at the index
//   insert: shifts up the points above the new one
//   delete: shifts down the points above the deleted one
//   move  : shifts the points in the slots crossed
// busy stays high during a walk; the next command can transfer in the
// same cycle as done.
//
// Reset clears the count and sets all markers to none; the point memory
// is not cleared since only slots below the count are ever read.
module sorted_envelope_point_table_core import sept_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  op_t     op,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic             accept;
    logic             idx_ok;
    logic             need_walk;
    logic [1:0]       imm_status;
    logic [CNT_W-1:0] count;
    mark_vec_t        marks;
    walk_req_t        wreq;
    walk_rsp_t        wrsp;
    mark_upd_t        upd;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    op_t              op_reg;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] res_idx_reg, res_idx_next;
    logic [DATA_W-1:0] rt_reg, rt_next;
    logic [DATA_W-1:0] rv_reg, rv_next;

    assign accept = start && !busy_reg;
    assign idx_ok = (op.point_index < count);

    // command decode: which commands walk memory, and early status
    always_comb
    begin
        need_walk  = 1'b0;
        imm_status = ST_OK;
        case (op.kind)
            KIND_INSERT:
                if (count == CNT_W'(MAX_POINTS))
                    imm_status = ST_FULL;
                else
                    need_walk = 1'b1;
            KIND_DELETE, KIND_MOVE, KIND_READ:
                if (idx_ok)
                    need_walk = 1'b1;
                else
                    imm_status = ST_RANGE;
            KIND_SETMARK:
                if (!(idx_ok || op.point_index == NONE_MARK))
                    imm_status = ST_RANGE;
            default:
                imm_status = ST_OK;
        endcase
    end

    // walk request built straight from the command ports
    always_comb
    begin
        wreq.go = accept && need_walk;
        case (op.kind)
            KIND_INSERT: wreq.mode = WM_INSERT;
            KIND_DELETE: wreq.mode = WM_DELETE;
            KIND_MOVE:   wreq.mode = WM_MOVE;
            default:     wreq.mode = WM_READ;
        endcase
        wreq.start_pos = (op.kind == KIND_INSERT) ? count[IDX_W-1:0]
                                                  : op.point_index[IDX_W-1:0];
        wreq.last_pos  = IDX_W'(count - 1'b1);
        wreq.t         = op.point_time;
        wreq.v         = op.point_value;
    end

    sept_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wreq),
        .rsp   (wrsp)
    );

    // marker / count update: marker writes at transfer, edits at walk end
    always_comb
    begin
        upd.en  = 1'b0;
        upd.op  = MK_SET;
        upd.a   = op.point_index;
        upd.b   = wrsp.pos;
        upd.sel = op.marker_select;
        if (accept && op.kind == KIND_SETMARK && imm_status == ST_OK)
            upd.en = 1'b1;
        else if (wrsp.done)
        begin
            upd.a = op_reg.point_index;
            case (op_reg.kind)
                KIND_INSERT:
                begin
                    upd.en = 1'b1;
                    upd.op = MK_INS;
                    upd.a  = CNT_W'(wrsp.pos);
                end
                KIND_DELETE:
                begin
                    upd.en = 1'b1;
                    upd.op = MK_DEL;
                end
                KIND_MOVE:
                begin
                    upd.en = 1'b1;
                    upd.op = MK_MOVE;
                end
                default:
                    upd.en = 1'b0;
            endcase
        end
    end

    sept_marks u_marks (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .count (count),
        .marks (marks)
    );

    // result fields
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        res_idx_next = res_idx_reg;
        rt_next      = rt_reg;
        rv_next      = rv_reg;
        if (accept && !need_walk)
        begin
            done_next    = 1'b1;
            status_next  = imm_status;
            res_idx_next = NONE_MARK;
            rt_next      = '0;
            rv_next      = '0;
        end
        else if (accept)
            busy_next = 1'b1;
        else if (wrsp.done)
        begin
            busy_next    = 1'b0;
            done_next    = 1'b1;
            status_next  = ST_OK;
            res_idx_next = CNT_W'(wrsp.pos);
            rt_next      = op_reg.point_time;
            rv_next      = op_reg.point_value;
            case (op_reg.kind)
                KIND_DELETE:
                begin
                    res_idx_next = NONE_MARK;
                    rt_next      = '0;
                    rv_next      = '0;
                end
                KIND_READ:
                begin
                    rt_next = wrsp.t;
                    rv_next = wrsp.v;
                end
                default:
                    res_idx_next = CNT_W'(wrsp.pos);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= op;
        status_reg  <= status_next;
        res_idx_reg <= res_idx_next;
        rt_reg      <= rt_next;
        rv_reg      <= rv_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // count and markers are live registers; they settled at the same edge
    always_comb
    begin
        result.status        = status_reg;
        result.result_index  = res_idx_reg;
        result.read_time     = rt_reg;
        result.read_value    = rv_reg;
        result.count_now     = count;
        result.sustain_first = marks[MARK_SUS_BEGIN];
        result.sustain_last  = marks[MARK_SUS_END];
        result.loop_first    = marks[MARK_LOOP_START];
        result.loop_last     = marks[MARK_LOOP_END];
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe during a walk");

    a_transfer_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("command transfer dropped");

endmodule

[hw/rtl/sept_walk.sv]
// Point memory plus the walk sequencer: one read, one compare and one
// write per step; a read state issues the read, a compare state the rest.
module sept_walk import sept_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  walk_req_t req,
    output walk_rsp_t rsp
);

    typedef enum logic [7:0] {
        W_IDLE   = 8'b0000_0001,
        W_DN_RD  = 8'b0000_0010,
        W_DN_CMP = 8'b0000_0100,
        W_UP_RD  = 8'b0000_1000,
        W_UP_CMP = 8'b0001_0000,
        W_GET_RD = 8'b0010_0000,
        W_DONE   = 8'b0100_0000
    } walk_state_t;

    walk_state_t state_reg, state_next;
    walk_mode_t  mode_reg, mode_next;
    logic [IDX_W-1:0]  h_reg, h_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic              first_reg, first_next;
    logic [DATA_W-1:0] t_reg, t_next;
    logic [DATA_W-1:0] v_reg, v_next;

    logic [2*DATA_W-1:0] mem [MAX_POINTS];
    logic [2*DATA_W-1:0] rd_q;
    logic                we, re;
    logic [IDX_W-1:0]    wa, ra;
    logic [2*DATA_W-1:0] wd;
    logic [DATA_W-1:0]   d_time;
    logic                cond_dn, cond_up;

    assign d_time = rd_q[2*DATA_W-1:DATA_W];

    // down walk: strict for insert and the first move step, then ties move too
    assign cond_dn = (mode_reg == WM_INSERT || first_reg) ? (t_reg < d_time)
                                                           : (t_reg <= d_time);
    assign cond_up = (mode_reg == WM_DELETE) ||
                     (first_reg ? (t_reg > d_time) : (t_reg >= d_time));

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        h_next     = h_reg;
        last_next  = last_reg;
        first_next = first_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        we = 1'b0;
        wa = h_reg;
        wd = {t_reg, v_reg};
        re = 1'b0;
        ra = h_reg;
        case (state_reg)
            W_IDLE:
            begin
                if (req.go)
                begin
                    mode_next  = req.mode;
                    h_next     = req.start_pos;
                    last_next  = req.last_pos;
                    first_next = 1'b1;
                    t_next     = req.t;
                    v_next     = req.v;
                    case (req.mode)
                        WM_READ:   state_next = W_GET_RD;
                        WM_DELETE: state_next = W_UP_RD;
                        default:   state_next = W_DN_RD;
                    endcase
                end
            end
            W_DN_RD:
            begin
                if (h_reg == '0)
                begin
                    if (mode_reg == WM_MOVE && first_reg)
                        state_next = W_UP_RD;
                    else
                    begin
                        we = 1'b1;
                        state_next = W_DONE;
                    end
                end
                else
                begin
                    re = 1'b1;
                    ra = h_reg - 1'b1;
                    state_next = W_DN_CMP;
                end
            end
            W_DN_CMP:
            begin
                if (cond_dn)
                begin
                    we = 1'b1;
                    wd = rd_q;
                    h_next = h_reg - 1'b1;
                    first_next = 1'b0;
                    state_next = W_DN_RD;
                end
                else if (mode_reg == WM_MOVE && first_reg)
                    state_next = W_UP_RD;
                else
                begin
                    we = 1'b1;
                    state_next = W_DONE;
                end
            end
            W_UP_RD:
            begin
                if (h_reg == last_reg)
                begin
                    we = (mode_reg != WM_DELETE);
                    state_next = W_DONE;
                end
                else
                begin
                    re = 1'b1;
                    ra = h_reg + 1'b1;
                    state_next = W_UP_CMP;
                end
            end
            W_UP_CMP:
            begin
                we = 1'b1;
                if (cond_up)
                begin
                    wd = rd_q;
                    h_next = h_reg + 1'b1;
                    first_next = 1'b0;
                    state_next = W_UP_RD;
                end
                else
                    state_next = W_DONE;
            end
            W_GET_RD:
            begin
                re = 1'b1;
                state_next = W_DONE;
            end
            W_DONE:
                state_next = W_IDLE;
            default:
                state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= W_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        h_reg     <= h_next;
        last_reg  <= last_next;
        first_reg <= first_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_q <= mem[ra];
    end

    assign rsp.done = (state_reg == W_DONE);
    assign rsp.pos  = h_reg;
    assign rsp.t    = rd_q[2*DATA_W-1:DATA_W];
    assign rsp.v    = rd_q[DATA_W-1:0];

    a_go_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> (state_reg == W_IDLE))
        else $error("walk started while busy");

    a_up_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == W_UP_CMP) |-> (h_reg < last_reg))
        else $error("up walk past last slot");

endmodule

[hw/rtl/sept_marks.sv]
// Point count and the four markers, updated on each finished edit and on each marker write.
module sept_marks import sept_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mark_upd_t        upd,
    output logic [CNT_W-1:0] count,
    output mark_vec_t        marks
);

    logic [CNT_W-1:0] count_reg, count_next;
    mark_vec_t        marks_reg, marks_next;
    logic             hit_sus, hit_loop, hit_pair;
    logic [CNT_W-1:0] b_ext;

    assign b_ext    = CNT_W'(upd.b);
    assign hit_sus  = (marks_reg[MARK_SUS_BEGIN] == upd.a) ||
                      (marks_reg[MARK_SUS_END] == upd.a);
    assign hit_loop = (marks_reg[MARK_LOOP_START] == upd.a) ||
                      (marks_reg[MARK_LOOP_END] == upd.a);

    always_comb
    begin
        count_next = count_reg;
        marks_next = marks_reg;
        hit_pair   = 1'b0;
        if (upd.en)
        begin
            case (upd.op)
                MK_INS:
                begin
                    count_next = CNT_W'(count_reg + 1'b1);
                    for (int k = 0; k < 4; k++)
                        if (marks_reg[k] != NONE_MARK && marks_reg[k] >= upd.a)
                            marks_next[k] = CNT_W'(marks_reg[k] + 1'b1);
                end
                MK_DEL:
                begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    for (int k = 0; k < 4; k++)
                    begin
                        hit_pair = (k < 2) ? hit_sus : hit_loop;
                        if (hit_pair)
                            marks_next[k] = NONE_MARK;
                        else if (marks_reg[k] != NONE_MARK && marks_reg[k] > upd.a)
                            marks_next[k] = CNT_W'(marks_reg[k] - 1'b1);
                    end
                end
                MK_MOVE:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (b_ext < upd.a && marks_reg[k] < upd.a && marks_reg[k] >= b_ext)
                            marks_next[k] = CNT_W'(marks_reg[k] + 1'b1);
                        else if (b_ext > upd.a && marks_reg[k] > upd.a &&
                                 marks_reg[k] <= b_ext)
                            marks_next[k] = CNT_W'(marks_reg[k] - 1'b1);
                    end
                end
                MK_SET:
                    marks_next[upd.sel] = upd.a;
                default:
                    marks_next = marks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            marks_reg <= {4{NONE_MARK}};
        end
        else
        begin
            count_reg <= count_next;
            marks_reg <= marks_next;
        end
    end

    assign count = count_reg;
    assign marks = marks_reg;

    a_sus_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (marks_reg[MARK_SUS_BEGIN] == NONE_MARK || marks_reg[MARK_SUS_BEGIN] < count_reg) &&
        (marks_reg[MARK_SUS_END] == NONE_MARK || marks_reg[MARK_SUS_END] < count_reg))
        else $error("sustain marker beyond table");

    a_loop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (marks_reg[MARK_LOOP_START] == NONE_MARK ||
         marks_reg[MARK_LOOP_START] < count_reg) &&
        (marks_reg[MARK_LOOP_END] == NONE_MARK || marks_reg[MARK_LOOP_END] < count_reg))
        else $error("loop marker beyond table");

endmodule
